@@ rtl/core/hsv_to_rgb_converter_core_defines.svh @@
// assertion macros used by the checker file
`ifndef HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HSV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

    // field widths
    localparam int HUE_W = 9;
    localparam int CH_W  = 8;
    localparam int VS_W  = 2 * CH_W;
    localparam int HM_W  = 7;
    localparam int D_W   = 6;
    localparam int SUM_W = 22;

    // arithmetic constants
    localparam int SECTOR_DEG  = 60;
    localparam int FULL_SCALE  = 255;
    localparam int DIVISOR     = SECTOR_DEG * FULL_SCALE;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (2 ** RECIP_SHIFT) / DIVISOR;
    localparam int RECIP_W     = 11;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // sector codes, listed as (red, green, blue) component order
    localparam int SEC_W = 3;
    localparam logic [SEC_W-1:0] SEC_CX0 = 3'd0;
    localparam logic [SEC_W-1:0] SEC_XC0 = 3'd1;
    localparam logic [SEC_W-1:0] SEC_0CX = 3'd2;
    localparam logic [SEC_W-1:0] SEC_0XC = 3'd3;
    localparam logic [SEC_W-1:0] SEC_X0C = 3'd4;
    localparam logic [SEC_W-1:0] SEC_C0X = 3'd5;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // after the first stage
    typedef struct packed {
        logic [VS_W-1:0]  vs;
        logic [CH_W-1:0]  v;
        logic [D_W-1:0]   d;
        logic [SEC_W-1:0] sector;
    } front_t;

    // per-channel numerators before the divide by DIVISOR
    typedef struct packed {
        logic [SUM_W-1:0] n_red;
        logic [SUM_W-1:0] n_green;
        logic [SUM_W-1:0] n_blue;
    } sum_t;

endpackage

@@ rtl/core/hsv2rgb_front.sv @@
module hsv2rgb_front
    import hsv2rgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   src_valid,
    input  pixel_t src,
    output logic   src_ready,
    output logic   dst_valid,
    output front_t dst,
    input  logic   dst_ready
);

    logic         valid_reg, valid_next;
    front_t       data_reg, data_next;
    logic [HUE_W-1:0] hm_wide;
    logic [HM_W-1:0]  hm;

    // stage can take a new transaction when empty or draining
    assign src_ready = !valid_reg || dst_ready;
    assign valid_next = src_ready ? src_valid : valid_reg;

    // hue mod 120 by a short compare chain
    always_comb
    begin
        if (src.hue >= HUE_W'(8 * SECTOR_DEG))
            hm_wide = src.hue - HUE_W'(8 * SECTOR_DEG);
        else if (src.hue >= HUE_W'(6 * SECTOR_DEG))
            hm_wide = src.hue - HUE_W'(6 * SECTOR_DEG);
        else if (src.hue >= HUE_W'(4 * SECTOR_DEG))
            hm_wide = src.hue - HUE_W'(4 * SECTOR_DEG);
        else if (src.hue >= HUE_W'(2 * SECTOR_DEG))
            hm_wide = src.hue - HUE_W'(2 * SECTOR_DEG);
        else
            hm_wide = src.hue;
        hm = hm_wide[HM_W-1:0];
    end

    // triangle weight, sector and v*s
    always_comb
    begin
        if (hm < HM_W'(SECTOR_DEG))
            data_next.d = hm[D_W-1:0];
        else
            data_next.d = D_W'(HM_W'(2 * SECTOR_DEG) - hm);

        if (src.hue < HUE_W'(SECTOR_DEG))
            data_next.sector = SEC_CX0;
        else if (src.hue < HUE_W'(2 * SECTOR_DEG))
            data_next.sector = SEC_XC0;
        else if (src.hue < HUE_W'(3 * SECTOR_DEG))
            data_next.sector = SEC_0CX;
        else if (src.hue < HUE_W'(4 * SECTOR_DEG))
            data_next.sector = SEC_0XC;
        else if (src.hue < HUE_W'(5 * SECTOR_DEG))
            data_next.sector = SEC_X0C;
        else
            data_next.sector = SEC_C0X;

        data_next.vs = VS_W'(src.saturation) * VS_W'(src.brightness);
        data_next.v  = src.brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (src_ready && src_valid)
            data_reg <= data_next;
    end

    assign dst_valid = valid_reg;
    assign dst       = data_reg;

endmodule

@@ rtl/core/hsv2rgb_mix.sv @@
module hsv2rgb_mix
    import hsv2rgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   src_valid,
    input  front_t src,
    output logic   src_ready,
    output logic   dst_valid,
    output sum_t   dst,
    input  logic   dst_ready
);

    // stage a: chroma, secondary and offset
    logic             a_valid_reg, a_valid_next, a_ready;
    logic [SUM_W-1:0] c_reg, c_next;
    logic [SUM_W-1:0] x_reg, x_next;
    logic [SUM_W-1:0] m_reg, m_next;
    logic [SEC_W-1:0] sec_reg;
    logic [SUM_W-1:0] v_full;

    // stage b: sector select and add
    logic b_valid_reg, b_valid_next, b_ready;
    sum_t sum_reg, sum_next;

    assign b_ready   = !b_valid_reg || dst_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign src_ready = a_ready;

    assign a_valid_next = a_ready ? src_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    // products in units of 1/(60*255*255)
    always_comb
    begin
        c_next = SUM_W'(src.vs) * SUM_W'(SECTOR_DEG);
        x_next = SUM_W'(src.vs) * SUM_W'(src.d);
        v_full = SUM_W'(src.v) * SUM_W'(DIVISOR);
        m_next = v_full - c_next;
    end

    // place chroma and secondary by sector, add offset
    always_comb
    begin
        case (sec_reg)
            SEC_CX0:
            begin
                sum_next.n_red   = c_reg + m_reg;
                sum_next.n_green = x_reg + m_reg;
                sum_next.n_blue  = m_reg;
            end
            SEC_XC0:
            begin
                sum_next.n_red   = x_reg + m_reg;
                sum_next.n_green = c_reg + m_reg;
                sum_next.n_blue  = m_reg;
            end
            SEC_0CX:
            begin
                sum_next.n_red   = m_reg;
                sum_next.n_green = c_reg + m_reg;
                sum_next.n_blue  = x_reg + m_reg;
            end
            SEC_0XC:
            begin
                sum_next.n_red   = m_reg;
                sum_next.n_green = x_reg + m_reg;
                sum_next.n_blue  = c_reg + m_reg;
            end
            SEC_X0C:
            begin
                sum_next.n_red   = x_reg + m_reg;
                sum_next.n_green = m_reg;
                sum_next.n_blue  = c_reg + m_reg;
            end
            default:
            begin
                sum_next.n_red   = c_reg + m_reg;
                sum_next.n_green = m_reg;
                sum_next.n_blue  = x_reg + m_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && src_valid)
        begin
            c_reg   <= c_next;
            x_reg   <= x_next;
            m_reg   <= m_next;
            sec_reg <= src.sector;
        end
        if (b_ready && a_valid_reg)
            sum_reg <= sum_next;
    end

    assign dst_valid = b_valid_reg;
    assign dst       = sum_reg;

endmodule

@@ rtl/core/hsv2rgb_div.sv @@
module hsv2rgb_div
    import hsv2rgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic src_valid,
    input  sum_t src,
    output logic src_ready,
    output logic dst_valid,
    output rgb_t dst,
    input  logic dst_ready
);

    localparam int LANES = 3;

    logic [SUM_W-1:0]  n_in [LANES];
    logic [PROD_W-1:0] prod [LANES];

    // stage a: reciprocal estimate, low by at most one
    logic             a_valid_reg, a_valid_next, a_ready;
    logic [SUM_W-1:0] n_reg  [LANES];
    logic [CH_W-1:0]  qe_reg [LANES];

    // stage b: remainder check and output register
    logic             b_valid_reg, b_valid_next, b_ready;
    logic [SUM_W-1:0] rem    [LANES];
    logic [CH_W-1:0]  q_next [LANES];
    logic [CH_W-1:0]  q_reg  [LANES];

    assign b_ready   = !b_valid_reg || dst_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign src_ready = a_ready;

    assign a_valid_next = a_ready ? src_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    assign n_in[0] = src.n_red;
    assign n_in[1] = src.n_green;
    assign n_in[2] = src.n_blue;

    // one lane per color channel
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod[i] = PROD_W'(n_in[i]) * PROD_W'(RECIP);
            rem[i]  = n_reg[i] - SUM_W'(qe_reg[i]) * SUM_W'(DIVISOR);
            if (rem[i] >= SUM_W'(DIVISOR))
                q_next[i] = qe_reg[i] + CH_W'(1);
            else
                q_next[i] = qe_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (a_ready && src_valid)
            begin
                n_reg[i]  <= n_in[i];
                qe_reg[i] <= prod[i][RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            end
            if (b_ready && a_valid_reg)
                q_reg[i] <= q_next[i];
        end
    end

    assign dst_valid = b_valid_reg;
    assign dst.red   = q_reg[0];
    assign dst.green = q_reg[1];
    assign dst.blue  = q_reg[2];

endmodule

@@ rtl/core/hsv_to_rgb_converter_core.sv @@
// channel   direction  handshake                 payload
// pixel     sink       pixel_valid / pixel_stall  pixel_t: hue, saturation, brightness
// rgb       source     rgb_valid / rgb_stall      rgb_t: red, green, blue
//
// one pixel per clock sustained when the output is not stalled; five register stages,
// front, mix a, mix b, div a and div b, lie between a pixel being taken and its result
// the stage depth is set by the v*s multiply, the chroma products, the sector add
// and the two-step reciprocal divide by 15300
// reset clears only the stage valid bits; no state survives between pixels
// a stall on rgb holds the output register and backs up stage by stage,
// bubbles in the pipe are still filled while the output waits
module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pixel_valid,
    output logic   pixel_stall,
    input  pixel_t pixel,
    output logic   rgb_valid,
    input  logic   rgb_stall,
    output rgb_t   rgb
);

    logic   front_ready;
    logic   front_valid, mix_ready;
    front_t front_data;
    logic   mix_valid, div_ready;
    sum_t   mix_data;

    assign pixel_stall = !front_ready;

    // hue folding, sector and v*s
    hsv2rgb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (pixel_valid),
        .src       (pixel),
        .src_ready (front_ready),
        .dst_valid (front_valid),
        .dst       (front_data),
        .dst_ready (mix_ready)
    );

    // chroma, offset and per-channel numerators
    hsv2rgb_mix u_mix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (front_valid),
        .src       (front_data),
        .src_ready (mix_ready),
        .dst_valid (mix_valid),
        .dst       (mix_data),
        .dst_ready (div_ready)
    );

    // constant divide, last stage is the output register
    hsv2rgb_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (mix_valid),
        .src       (mix_data),
        .src_ready (div_ready),
        .dst_valid (rgb_valid),
        .dst       (rgb),
        .dst_ready (!rgb_stall)
    );

endmodule

@@ rtl/core/hsv2rgb_checker.sv @@
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv2rgb_checker
    import hsv2rgb_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   pixel_valid,
    input logic   pixel_stall,
    input pixel_t pixel,
    input logic   rgb_valid,
    input logic   rgb_stall,
    input rgb_t   rgb
);

    // a stalled result stays put
    `HSV_ASSERT_NEXT(a_rgb_hold, rgb_valid && rgb_stall, rgb_valid && $stable(rgb), "rgb changed while stalled")

    // with the output empty the whole pipe can move
    `HSV_ASSERT_NOW(a_no_stall_empty, !rgb_valid, !pixel_stall, "pixel stalled with empty output")

    // zero brightness gives black when rgb is not stalled meanwhile
    `HSV_ASSERT_NEXT(a_black, pixel_valid && !pixel_stall && pixel.brightness == 8'd0 && !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall, rgb_valid && rgb.red == 8'd0 && rgb.green == 8'd0 && rgb.blue == 8'd0, "black pixel not produced")

    // zero saturation gives equal channels
    `HSV_ASSERT_NEXT(a_gray, pixel_valid && !pixel_stall && pixel.saturation == 8'd0 && !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall, rgb_valid && rgb.red == rgb.green && rgb.green == rgb.blue, "gray pixel has unequal channels")

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker u_hsv2rgb_checker (.*);

@@ verif/hsv_to_rgb_converter_core_tb.sv @@
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core_tb;
    import hsv2rgb_pkg::*;

    localparam int RANDOM_PIXELS = 830;
    localparam int TAIL_ITEMS    = 100;
    localparam int DRAIN_CYCLES  = 20;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int HOLD_AFTER    = 150;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   pixel_valid = 1'b0;
    logic   pixel_stall;
    pixel_t pixel = '0;
    logic   rgb_valid;
    logic   rgb_stall = 1'b0;
    rgb_t   rgb;

    pixel_t pixel_queue[$];
    rgb_t   expected_rgb[$];
    int     fail_count = 0;
    int     rgb_seen = 0;
    logic   quiet_tail = 1'b0;

    hsv_to_rgb_converter_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .rgb_valid   (rgb_valid),
        .rgb_stall   (rgb_stall),
        .rgb         (rgb)
    );

    always #5 clk = ~clk;

    // six-sector hsv rule in units of 1/(60*255*255), one truncating divide per channel
    function automatic rgb_t predict_rgb(pixel_t p);
        int unsigned      hue_mod;
        int unsigned      hue_dist;
        int unsigned      vs;
        int unsigned      chroma;
        int unsigned      second;
        int unsigned      offset;
        int unsigned      r_sum;
        int unsigned      g_sum;
        int unsigned      b_sum;
        logic [SEC_W-1:0] sector;
        rgb_t             out;
        hue_mod  = p.hue % (2 * SECTOR_DEG);
        hue_dist = (hue_mod >= SECTOR_DEG) ? hue_mod - SECTOR_DEG : SECTOR_DEG - hue_mod;
        vs       = p.brightness * p.saturation;
        chroma   = vs * SECTOR_DEG;
        second   = vs * (SECTOR_DEG - hue_dist);
        offset   = p.brightness * FULL_SCALE * SECTOR_DEG - chroma;
        // out-of-range hues land in the last sector
        if (p.hue < 60)
            sector = SEC_CX0;
        else if (p.hue < 120)
            sector = SEC_XC0;
        else if (p.hue < 180)
            sector = SEC_0CX;
        else if (p.hue < 240)
            sector = SEC_0XC;
        else if (p.hue < 300)
            sector = SEC_X0C;
        else
            sector = SEC_C0X;
        case (sector)
            SEC_CX0: begin r_sum = chroma; g_sum = second; b_sum = 0;      end
            SEC_XC0: begin r_sum = second; g_sum = chroma; b_sum = 0;      end
            SEC_0CX: begin r_sum = 0;      g_sum = chroma; b_sum = second; end
            SEC_0XC: begin r_sum = 0;      g_sum = second; b_sum = chroma; end
            SEC_X0C: begin r_sum = second; g_sum = 0;      b_sum = chroma; end
            default: begin r_sum = chroma; g_sum = 0;      b_sum = second; end
        endcase
        out.red   = CH_W'((r_sum + offset) / DIVISOR);
        out.green = CH_W'((g_sum + offset) / DIVISOR);
        out.blue  = CH_W'((b_sum + offset) / DIVISOR);
        return out;
    endfunction

    task automatic add_pixel(int unsigned h, int unsigned s, int unsigned v);
        pixel_t p;
        p.hue        = HUE_W'(h);
        p.saturation = CH_W'(s);
        p.brightness = CH_W'(v);
        pixel_queue.push_back(p);
    endtask

    function automatic int unsigned pick_channel();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return 0;
        else if (sel == 1)
            return 255;
        else
            return $urandom_range(0, 255);
    endfunction

    task automatic check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // driver: offers queued pixels, random idle bursts, predicts on each transaction
    int   gap_left = 0;
    int   pixel_idle_odds = 3;
    logic offering = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            pixel_valid <= 1'b0;
        end
        else begin
            if (pixel_valid && !pixel_stall) begin
                expected_rgb.push_back(predict_rgb(pixel));
                offering = 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                pixel_idle_odds = $urandom_range(0, 4);
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (!quiet_tail && pixel_idle_odds != 0
                         && $urandom_range(1, 10) <= pixel_idle_odds) begin
                    gap_left = $urandom_range(0, 8);
                end
                else if (pixel_queue.size() > 0) begin
                    pixel <= pixel_queue.pop_front();
                    offering = 1'b1;
                end
            end
            pixel_valid <= offering;
        end
        quiet_tail <= (pixel_queue.size() < TAIL_ITEMS);
    end

    // monitor: checks each rgb transaction, drives stall bursts and one long hold
    int   stall_left = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   rgb_idle_odds = 2;

    always @(posedge clk) begin
        rgb_t want;
        if (!rst_n) begin
            rgb_stall <= 1'b0;
        end
        else begin
            if (rgb_valid && !rgb_stall) begin
                rgb_seen++;
                if (expected_rgb.size() == 0) begin
                    $error("rgb transaction with nothing expected: %h", rgb);
                    fail_count++;
                end
                else begin
                    want = expected_rgb.pop_front();
                    check_field("red", want.red, rgb.red);
                    check_field("green", want.green, rgb.green);
                    check_field("blue", want.blue, rgb.blue);
                end
            end
            if ($urandom_range(0, 63) == 0)
                rgb_idle_odds = $urandom_range(0, 4);
            if (hold_left > 0) begin
                hold_left--;
                rgb_stall <= 1'b1;
            end
            else if (!hold_done && rgb_seen >= HOLD_AFTER) begin
                // long hold so the pipe fills and backs up onto the input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rgb_stall <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                rgb_stall <= 1'b1;
            end
            else if (!quiet_tail && rgb_idle_odds != 0
                     && $urandom_range(1, 10) <= rgb_idle_odds) begin
                stall_left = $urandom_range(0, 8);
                rgb_stall <= 1'b1;
            end
            else begin
                rgb_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((pixel_valid && !pixel_stall) || (rgb_valid && !rgb_stall)) begin
                quiet_cycles = 0;
            end
            else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        int unsigned h;
        // sector boundaries at full saturation and value
        add_pixel(0, 255, 255);
        add_pixel(59, 255, 255);
        add_pixel(60, 255, 255);
        add_pixel(119, 255, 255);
        add_pixel(120, 255, 255);
        add_pixel(179, 255, 255);
        add_pixel(180, 255, 255);
        add_pixel(239, 255, 255);
        add_pixel(240, 255, 255);
        add_pixel(299, 255, 255);
        add_pixel(300, 255, 255);
        add_pixel(359, 255, 255);
        // gray, black, smallest nonzero and mid-range inputs
        add_pixel(200, 0, 200);
        add_pixel(45, 255, 0);
        add_pixel(0, 0, 0);
        add_pixel(1, 1, 1);
        add_pixel(90, 128, 77);
        add_pixel(30, 200, 255);
        add_pixel(270, 17, 254);
        // hue beyond 359 falls in the last sector, plus in-range hue 256
        add_pixel(360, 255, 255);
        add_pixel(420, 255, 255);
        add_pixel(480, 200, 150);
        add_pixel(511, 255, 255);
        add_pixel(256, 255, 255);
        // random pixels, mostly in range
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if ($urandom_range(0, 7) == 0)
                h = $urandom_range(360, 511);
            else
                h = $urandom_range(0, 359);
            add_pixel(h, pick_channel(), pick_channel());
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pixel_queue.size() != 0 || pixel_valid || expected_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_rgb.size() != 0) begin
            $error("%0d rgb transactions never arrived", expected_rgb.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
